/* design/rne_pkg.sv */
// Shared types, constants and helper functions for the Roman numeral encoder.
// Used by rne_front, rne_queue, rne_back and roman_numeral_encoder.
// No dependencies.
package rne_pkg;

	// Largest number that has a Roman numeral in this encoder
	localparam int unsigned MaxValue = 3999;

	// Depth of the queue between front and back
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CountW     = $clog2(QueueDepth + 1);

	typedef logic [3:0]  digit_t;
	typedef logic [11:0] rem_t;
	typedef logic [7:0]  sym_t;

	// One classified request: error flag and decimal digits, [3] = thousands
	typedef struct packed {
		logic             err;
		digit_t [3:0]     dig;
	} entry_t;

	// Place values of the front's digit steps
	localparam rem_t UnitThousand = 12'd1000;
	localparam rem_t UnitHundred  = 12'd100;
	localparam rem_t UnitTen      = 12'd10;

	// ASCII codes of the symbols
	localparam sym_t SymM = 8'h4D;
	localparam sym_t SymD = 8'h44;
	localparam sym_t SymC = 8'h43;
	localparam sym_t SymL = 8'h4C;
	localparam sym_t SymX = 8'h58;
	localparam sym_t SymV = 8'h56;
	localparam sym_t SymI = 8'h49;
	localparam sym_t SymNone = 8'h00;

	// Symbols per place, index 0 = units ... 3 = thousands
	localparam sym_t [3:0] SymOne  = {SymM, SymC, SymX, SymI};
	localparam sym_t [3:0] SymFive = {SymNone, SymD, SymL, SymV};
	localparam sym_t [3:0] SymTen  = {SymNone, SymM, SymC, SymX};

	// Decimal digit of rem at the given place value (rem < 10 * unit)
	function automatic digit_t digit_of(rem_t rem, rem_t unit);
		digit_t     d;
		logic [13:0] lim;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			lim = 14'(k) * 14'(unit);
			if (14'(rem) >= lim)
				d = 4'(k);
		end
		return d;
	endfunction

	// Remainder after taking that digit off
	function automatic rem_t rem_after(rem_t rem, rem_t unit, digit_t d);
		rem_t prod;
		prod = rem_t'(d) * unit;
		return rem - prod;
	endfunction

	// Number of characters a digit spells out
	function automatic logic [2:0] digit_len(digit_t d);
		logic [2:0] n;
		case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Character at position pos of digit d at the given place
	function automatic sym_t sym_of(logic [1:0] place, digit_t d, logic [1:0] pos);
		sym_t s;
		if (d == 4'd9)
			s = (pos == 2'd0) ? SymOne[place] : SymTen[place];
		else if (d == 4'd4)
			s = (pos == 2'd0) ? SymOne[place] : SymFive[place];
		else if (d >= 4'd5)
			s = (pos == 2'd0) ? SymFive[place] : SymOne[place];
		else
			s = SymOne[place];
		return s;
	endfunction

endpackage

/* design/rne_front.sv */
// Front end: accepts numbers, flags out-of-range ones and splits the rest
// into decimal digits (thousands, hundreds, then tens and units together), one step per cycle. Depends on rne_pkg.
module rne_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [15:0]           value,
	output logic                  full,
	output logic                  q_push,
	output rne_pkg::entry_t       q_entry,
	input  logic                  q_full
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_THOU,
		F_HUND,
		F_TENS,
		F_PUSH
	} front_state_t;

	front_state_t     state_q;
	rne_pkg::rem_t    rem_q;
	rne_pkg::entry_t  ent_q;

	logic             in_err;
	rne_pkg::rem_t    unit;
	rne_pkg::digit_t  dig_c;
	rne_pkg::rem_t    rem_c;

	// range check on the incoming number
	assign in_err = (value == 16'd0) || (value > 16'(rne_pkg::MaxValue));

	// one digit step per cycle
	always_comb begin
		case (state_q)
			F_THOU:  unit = rne_pkg::UnitThousand;
			F_HUND:  unit = rne_pkg::UnitHundred;
			default: unit = rne_pkg::UnitTen;
		endcase
		dig_c = rne_pkg::digit_of(rem_q, unit);
		rem_c = rne_pkg::rem_after(rem_q, unit, dig_c);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						ent_q.err <= in_err;
						rem_q     <= value[11:0];
						state_q   <= in_err ? F_PUSH : F_THOU;
					end
				end
				F_THOU: begin
					ent_q.dig[3] <= dig_c;
					rem_q        <= rem_c;
					state_q      <= F_HUND;
				end
				F_HUND: begin
					ent_q.dig[2] <= dig_c;
					rem_q        <= rem_c;
					state_q      <= F_TENS;
				end
				F_TENS: begin
					ent_q.dig[1] <= dig_c;
					ent_q.dig[0] <= rem_c[3:0];
					state_q      <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign full    = (state_q != F_IDLE);
	assign q_push  = (state_q == F_PUSH) && !q_full;
	assign q_entry = ent_q;

endmodule

/* design/rne_queue.sv */
// Short queue of classified requests between front and back.
// Depends on rne_pkg.
module rne_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  rne_pkg::entry_t  wr_entry,
	output logic             full,
	input  logic             rd_en,
	output rne_pkg::entry_t  rd_entry,
	output logic             empty
);

	rne_pkg::entry_t                  mem_q [rne_pkg::QueueDepth];
	logic [rne_pkg::PtrW-1:0]         wr_ptr_q;
	logic [rne_pkg::PtrW-1:0]         rd_ptr_q;
	logic [rne_pkg::CountW-1:0]       count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full  = (count_q == rne_pkg::CountW'(rne_pkg::QueueDepth));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	assign rd_entry = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == rne_pkg::PtrW'(rne_pkg::QueueDepth - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				if (rd_ptr_q == rne_pkg::PtrW'(rne_pkg::QueueDepth - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* design/rne_back.sv */
// Back end: walks a request's digits from thousands down, emitting one Roman
// symbol per cycle while the output register is free or popped. Depends on rne_pkg.
module rne_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rne_pkg::entry_t  q_entry,
	input  logic             q_empty,
	output logic             q_pop,
	output logic [7:0]       symbol,
	output logic             last,
	output logic             error,
	output logic             empty,
	input  logic             pop
);

	logic                busy_q;
	rne_pkg::entry_t     ent_q;
	logic [1:0]          place_q;
	logic [1:0]          pos_q;
	logic                out_v_q;
	rne_pkg::sym_t       sym_q;
	logic                last_q;
	logic                err_q;

	rne_pkg::digit_t     cur_d;
	logic [2:0]          cur_len;
	logic                rest_zero;
	logic                pos_end;
	logic                can_out;
	logic                fire;
	rne_pkg::sym_t       cur_sym;

	// current digit and whether it finishes the numeral
	always_comb begin
		cur_d     = ent_q.dig[place_q];
		cur_len   = rne_pkg::digit_len(cur_d);
		cur_sym   = rne_pkg::sym_of(place_q, cur_d, pos_q);
		pos_end   = ((3'(pos_q) + 3'd1) == cur_len);
		rest_zero = 1'b1;
		for (int p = 0; p < 4; p++) begin
			if ((2'(p) < place_q) && (ent_q.dig[p] != 4'd0))
				rest_zero = 1'b0;
		end
	end

	assign can_out = !out_v_q || pop;
	assign q_pop   = !busy_q && !q_empty;
	// a symbol goes into the output register this cycle
	assign fire    = busy_q && can_out && (ent_q.err || (cur_len != 3'd0));

	// digit walker and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
			place_q <= '0;
			pos_q   <= '0;
		end else begin
			if (fire)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;

			if (!busy_q) begin
				if (!q_empty) begin
					ent_q   <= q_entry;
					busy_q  <= 1'b1;
					place_q <= 2'd3;
					pos_q   <= 2'd0;
				end
			end else if (ent_q.err) begin
				if (can_out) begin
					sym_q   <= rne_pkg::SymNone;
					last_q  <= 1'b1;
					err_q   <= 1'b1;
					busy_q  <= 1'b0;
				end
			end else if (cur_len == 3'd0) begin
				// zero digit spells nothing
				if (place_q == 2'd0)
					busy_q <= 1'b0;
				else
					place_q <= place_q - 1'b1;
			end else if (can_out) begin
				sym_q   <= cur_sym;
				last_q  <= pos_end && rest_zero;
				err_q   <= 1'b0;
				if (pos_end) begin
					if (rest_zero || (place_q == 2'd0)) begin
						busy_q <= 1'b0;
					end else begin
						place_q <= place_q - 1'b1;
						pos_q   <= 2'd0;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign symbol = sym_q;
	assign last   = last_q;
	assign error  = err_q;
	assign empty  = !out_v_q;

endmodule

/* design/roman_numeral_encoder.sv */
// Roman numeral encoder, top level: front end, request queue and back end.
// Depends on rne_pkg, rne_front, rne_queue and rne_back.
//
// Each number pushed in comes out as its Roman numeral (subtractive form),
// one ASCII symbol per result, most significant first, with last set on the
// final symbol. Zero and numbers above 3999 give a single result with symbol
// 0, last 1 and error 1. The front end takes a number, splits it into decimal
// digits (thousands, hundreds, then tens and units together), then hands it to
// the two-deep queue; full is high from the cycle after acceptance until the
// request enters the queue, so the front end holds only one number at a time.
// The back end emits one symbol per cycle while its output register is free or
// popped, loads each request before its first symbol and passes over each zero
// digit above the lowest nonzero one without emitting. A numeral has at most 15
// symbols. With the output popped every cycle the slower side sets the
// sustained rate: the back end for long numerals, the front end for short ones.
module roman_numeral_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [15:0] value,
	output logic        full,
	output logic [7:0]  symbol,
	output logic        last,
	output logic        error,
	output logic        empty,
	input  logic        pop
);

	logic             fq_push;
	rne_pkg::entry_t  fq_entry;
	logic             fq_full;
	logic             qb_pop;
	rne_pkg::entry_t  qb_entry;
	logic             qb_empty;

	// classify and split
	rne_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.value   (value),
		.full    (full),
		.q_push  (fq_push),
		.q_entry (fq_entry),
		.q_full  (fq_full)
	);

	// decoupling queue
	rne_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fq_push),
		.wr_entry (fq_entry),
		.full     (fq_full),
		.rd_en    (qb_pop),
		.rd_entry (qb_entry),
		.empty    (qb_empty)
	);

	// symbol emission
	rne_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (qb_entry),
		.q_empty (qb_empty),
		.q_pop   (qb_pop),
		.symbol  (symbol),
		.last    (last),
		.error   (error),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

/* tb/sv/roman_numeral_checker.sv */
`timescale 1ns / 100ps
// Checker for the Roman numeral encoder: watches the request and symbol queues,
// spells each accepted number and compares the symbols field by field.
// Depends on rne_pkg for the symbol codes and the upper bound.
module roman_numeral_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [15:0] value,
	input  logic        pop,
	input  logic        empty,
	input  logic [7:0]  symbol,
	input  logic        last,
	input  logic        error,
	output int          fails,
	output int          pending,
	output int          checked
);

	typedef struct {
		rne_pkg::sym_t symbol;
		logic          last;
		logic          error;
	} glyph_t;

	glyph_t numeral_q[$];
	glyph_t want;
	int     fail_cnt    = 0;
	int     pending_cnt = 0;
	int     checked_cnt = 0;

	assign fails   = fail_cnt;
	assign pending = pending_cnt;
	assign checked = checked_cnt;

	// Append the symbols expected for one number to the queue
	task automatic spell_numeral(input logic [15:0] num);
		rne_pkg::sym_t word[$];
		int            d;
		int unsigned   scale;
		glyph_t        g;
		if (num == 16'd0 || num > rne_pkg::MaxValue) begin
			g.symbol = rne_pkg::SymNone;
			g.last   = 1'b1;
			g.error  = 1'b1;
			numeral_q.push_back(g);
			return;
		end
		scale = 1000;
		for (int p = 3; p >= 0; p--) begin
			d = (num / scale) % 10;
			if (d == 9) begin
				word.push_back(rne_pkg::SymOne[p]);
				word.push_back(rne_pkg::SymTen[p]);
			end else if (d == 4) begin
				word.push_back(rne_pkg::SymOne[p]);
				word.push_back(rne_pkg::SymFive[p]);
			end else begin
				if (d >= 5) begin
					word.push_back(rne_pkg::SymFive[p]);
					d -= 5;
				end
				repeat (d) word.push_back(rne_pkg::SymOne[p]);
			end
			scale = scale / 10;
		end
		for (int i = 0; i < word.size(); i++) begin
			g.symbol = word[i];
			g.last   = (i == word.size() - 1);
			g.error  = 1'b0;
			numeral_q.push_back(g);
		end
	endtask

	// Compare popped symbols first, then record newly accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (numeral_q.size() == 0) begin
					$error("symbol %h popped with nothing expected", symbol);
					fail_cnt++;
				end else begin
					want = numeral_q.pop_front();
					checked_cnt++;
					if (symbol !== want.symbol) begin
						$error("symbol: expected %h, got %h", want.symbol, symbol);
						fail_cnt++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						fail_cnt++;
					end
					if (error !== want.error) begin
						$error("error: expected %b, got %b", want.error, error);
						fail_cnt++;
					end
				end
			end
			if (push && !full)
				spell_numeral(value);
			pending_cnt = numeral_q.size();
		end
	end

endmodule

/* tb/sv/roman_numeral_encoder_test.sv */
`timescale 1ns / 100ps
// Top of the Roman numeral encoder testbench: clock, reset, request stimulus
// and symbol popping. Depends on roman_numeral_encoder and roman_numeral_checker.
module roman_numeral_encoder_test;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic [15:0] value  = '0;
	logic        pop    = 1'b0;
	logic        full;
	logic [7:0]  symbol;
	logic        last;
	logic        error;
	logic        empty;
	int          fails;
	int          pending;
	int          checked;
	bit          calm   = 1'b0;
	int          n_sent = 0;
	int          n_bad  = 0;

	roman_numeral_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.value  (value),
		.full   (full),
		.symbol (symbol),
		.last   (last),
		.error  (error),
		.empty  (empty),
		.pop    (pop)
	);

	roman_numeral_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.value   (value),
		.pop     (pop),
		.empty   (empty),
		.symbol  (symbol),
		.last    (last),
		.error   (error),
		.fails   (fails),
		.pending (pending),
		.checked (checked)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one number; returns at the edge where the request is taken
	task automatic offer(input logic [15:0] num);
		push  <= 1'b1;
		value <= num;
		do @(negedge clk); while (full);
		@(posedge clk);
		n_sent++;
		if (num == 16'd0 || num > rne_pkg::MaxValue)
			n_bad++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Hold off until every expected symbol has been popped
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Symbol side: pop, with random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Request side
	initial begin
		logic [15:0] directed[$];
		logic [15:0] num;
		directed = '{16'd1, 16'd3999, 16'd0, 16'd4000, 16'd65535, 16'd4, 16'd9,
			16'd40, 16'd90, 16'd400, 16'd900, 16'd3888, 16'd5, 16'd50, 16'd500,
			16'd1000, 16'd3, 16'd1994, 16'd1100, 16'd1500, 16'd49, 16'd649,
			16'd707, 16'd3000, 16'd10};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i]);
		drain();

		// random numbers: mostly valid, some tiny, some long, some out of range
		for (int i = 0; i < 320; i++) begin
			if (i == 150)
				drain();
			if (i == 270)
				calm = 1'b1;
			case ($urandom_range(0, 9))
				0:       num = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(4000, 65535));
				1:       num = 16'($urandom_range(1, 99));
				2:       num = 16'($urandom_range(3000, 3999));
				default: num = 16'($urandom_range(1, 3999));
			endcase
			offer(num);
		end
		push <= 1'b0;

		// let the last symbols out, then watch for strays
		do @(negedge clk); while (pending != 0);
		repeat (30) @(posedge clk);

		$display("Sent %0d numbers (%0d out of range), checked %0d symbols,",
			n_sent, n_bad, checked);
		$display("with stall bursts on both queues and two full drains.");
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timed out with %0d symbols still expected", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
design/rne_pkg.sv
design/rne_front.sv
design/rne_queue.sv
design/rne_back.sv
design/roman_numeral_encoder.sv
tb/sv/roman_numeral_checker.sv
tb/sv/roman_numeral_encoder_test.sv
